>>> hw/rtl/nqs_pkg.sv
// Shared types and constants for the n-queens first-solution search block.
package nqs_pkg;

  localparam int unsigned MaxSizeDefault = 16;

  localparam int unsigned BoardSizeW = 5;
  localparam int unsigned RowIdxW    = 4;
  localparam int unsigned ColIdxW    = 4;

  typedef struct packed {
    logic [BoardSizeW-1:0] board_size;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [RowIdxW-1:0] row_index;
    logic [ColIdxW-1:0] queen_column;
    logic               last;
  } res_t;

endpackage

>>> hw/rtl/nqs_if.sv
// Valid/ready stream interfaces for search requests and per-row results.
interface nqs_req_if;
  logic          valid;
  logic          ready;
  nqs_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface nqs_res_if;
  logic          valid;
  logic          ready;
  nqs_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/n_queens_first_solution_search.sv
// N-queens first-solution search: one request in, one result per board row out (a single one if none found).
//
// req_i carries a board size; a transfer takes place when valid and ready are both
// high. ready is high only while the block is idle. The search is depth-first
// backtracking: rows are filled from 0 upward, columns tried from lowest to
// highest, so the first solution in that order is returned.
// Each cycle of the search does one step with a single shared square checker:
// test one column and place a queen there if it is free, or take one queen back.
// A search starts, tries squares, backtracks where needed and closes the search,
// and then hands the results over in row order.
// Results leave on res_o, one per row, with last set on the final row. A size of
// zero, a size above MAX_SIZE, or a board with no solution gives a single result
// with found clear and last set.
// res_o holds its payload while the receiver stalls; the next row is shown only
// after the current one has been transferred, and the block returns to idle
// after the final transfer.
// Reset clears the occupancy vectors, the row and column counters and the
// sequencer; the stack of placed columns needs no reset.
module n_queens_first_solution_search #(
  parameter int unsigned MAX_SIZE = nqs_pkg::MaxSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nqs_req_if.sink     req_i,
  nqs_res_if.source   res_o
);

  localparam int unsigned RowW  = $clog2(MAX_SIZE + 1);
  localparam int unsigned IdxW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned DiagN = 2 * MAX_SIZE - 1;
  localparam int unsigned DiagW = (DiagN > 1) ? $clog2(DiagN) : 1;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StEmit   = 2'd2;

  localparam logic [nqs_pkg::BoardSizeW:0] MaxSizeVal = (nqs_pkg::BoardSizeW + 1)'(MAX_SIZE);

  logic [1:0]       state_q, state_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [RowW-1:0]  col_q, col_d;
  logic [RowW-1:0]  n_q, n_d;
  logic [IdxW-1:0]  emit_row_q, emit_row_d;
  logic             found_q, found_d;
  logic [MAX_SIZE-1:0] col_taken_q, col_taken_d;
  logic [DiagN-1:0] fall_taken_q, fall_taken_d;
  logic [DiagN-1:0] rise_taken_q, rise_taken_d;

  logic [IdxW-1:0]  stack_q [MAX_SIZE];
  logic             stack_we;
  logic [IdxW-1:0]  stack_rd_addr;
  logic [IdxW-1:0]  stack_rd_data;

  logic [IdxW-1:0]  unit_row, unit_col;
  logic [DiagW:0]   fall_sum, rise_sum;
  logic [DiagW-1:0] fall_idx, rise_idx;
  logic             sq_free;
  logic [IdxW-1:0]  back_row;
  logic             req_xfer, res_xfer, res_last;

  assign req_i.ready = (state_q == StIdle);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign res_o.valid = (state_q == StEmit);
  assign res_xfer    = res_o.valid && res_o.ready;

  assign back_row      = IdxW'(row_q - RowW'(1));
  assign stack_rd_addr = (state_q == StEmit) ? emit_row_q : back_row;
  assign stack_rd_data = stack_q[stack_rd_addr];

  // Shared square checker: tries (row, col) while searching, and names the
  // diagonals of the queen being taken back when backtracking.
  always_comb begin
    if (col_q == n_q) begin
      unit_row = back_row;
      unit_col = stack_rd_data;
    end else begin
      unit_row = row_q[IdxW-1:0];
      unit_col = col_q[IdxW-1:0];
    end
  end

  assign fall_sum = (DiagW + 1)'(unit_row) + (DiagW + 1)'(MAX_SIZE - 1)
                  - (DiagW + 1)'(unit_col);
  assign rise_sum = (DiagW + 1)'(unit_row) + (DiagW + 1)'(unit_col);
  assign fall_idx = fall_sum[DiagW-1:0];
  assign rise_idx = rise_sum[DiagW-1:0];
  assign sq_free  = !col_taken_q[unit_col] && !fall_taken_q[fall_idx]
                    && !rise_taken_q[rise_idx];

  assign res_last = found_q ? ((RowW'(emit_row_q) + RowW'(1)) == n_q) : 1'b1;

  assign res_o.payload.found        = found_q;
  assign res_o.payload.row_index    = found_q ? nqs_pkg::RowIdxW'(emit_row_q) : '0;
  assign res_o.payload.queen_column = found_q ? nqs_pkg::ColIdxW'(stack_rd_data) : '0;
  assign res_o.payload.last         = res_last;

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    n_d          = n_q;
    emit_row_d   = emit_row_q;
    found_d      = found_q;
    col_taken_d  = col_taken_q;
    fall_taken_d = fall_taken_q;
    rise_taken_d = rise_taken_q;
    stack_we     = 1'b0;

    case (state_q)
      StIdle: begin
        if (req_xfer) begin
          row_d        = '0;
          col_d        = '0;
          emit_row_d   = '0;
          col_taken_d  = '0;
          fall_taken_d = '0;
          rise_taken_d = '0;
          n_d          = RowW'(req_i.payload.board_size);
          if (req_i.payload.board_size == '0 ||
              {1'b0, req_i.payload.board_size} > MaxSizeVal) begin
            found_d = 1'b0;
            state_d = StEmit;
          end else begin
            state_d = StSearch;
          end
        end
      end
      StSearch: begin
        if (row_q == n_q) begin
          found_d    = 1'b1;
          emit_row_d = '0;
          state_d    = StEmit;
        end else if (col_q != n_q) begin
          if (sq_free) begin
            stack_we               = 1'b1;
            col_taken_d[unit_col]  = 1'b1;
            fall_taken_d[fall_idx] = 1'b1;
            rise_taken_d[rise_idx] = 1'b1;
            row_d                  = row_q + RowW'(1);
            col_d                  = '0;
          end else begin
            col_d = col_q + RowW'(1);
          end
        end else if (row_q == '0) begin
          found_d = 1'b0;
          state_d = StEmit;
        end else begin
          // Take back the queen of the row above and resume after its column.
          col_taken_d[unit_col]  = 1'b0;
          fall_taken_d[fall_idx] = 1'b0;
          rise_taken_d[rise_idx] = 1'b0;
          row_d                  = RowW'(back_row);
          col_d                  = RowW'(stack_rd_data) + RowW'(1);
        end
      end
      StEmit: begin
        if (res_xfer) begin
          if (res_last) begin
            state_d = StIdle;
          end else begin
            emit_row_d = emit_row_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      row_q        <= '0;
      col_q        <= '0;
      col_taken_q  <= '0;
      fall_taken_q <= '0;
      rise_taken_q <= '0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      col_taken_q  <= col_taken_d;
      fall_taken_q <= fall_taken_d;
      rise_taken_q <= rise_taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    emit_row_q <= emit_row_d;
    found_q    <= found_d;
    if (stack_we) begin
      stack_q[row_q[IdxW-1:0]] <= col_q[IdxW-1:0];
    end
  end

  // One queen per placed row in every occupancy vector.
  a_col_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSearch |-> $countones(col_taken_q) == row_q)
    else $error("column occupancy does not match placed rows");

  a_fall_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSearch |-> $countones(fall_taken_q) == row_q)
    else $error("falling diagonal occupancy does not match placed rows");

  a_rise_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSearch |-> $countones(rise_taken_q) == row_q)
    else $error("rising diagonal occupancy does not match placed rows");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSearch |-> row_q <= n_q && col_q <= n_q)
    else $error("search counters beyond board size");

  a_not_found_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.payload.found |-> res_o.payload.last)
    else $error("not-found result is not the final one");

endmodule
